@@ design/stp_pkg.sv @@
// Shared constants and types for the sky texture coordinate projection block.
package stp_pkg;

  localparam int VW    = 24;  // vertex, view and texture coordinate width
  localparam int AZW   = 26;  // magnitude of the tripled vertical component
  localparam int SQW   = 52;  // sum of squares width
  localparam int RTW   = 26;  // square root width, also the number of root stages
  localparam int RMW   = 28;  // root remainder width
  localparam int GAINW = 18;
  localparam int NUMW  = VW + GAINW;  // dividend width, also the number of divide stages
  localparam int DRW   = RTW + 1;     // divide remainder width
  localparam int TW    = 32;          // sky time width
  localparam int SPW   = 8;           // scroll speed width
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // 378 * 512: maps the direction in Q.8 over the length to Q.16 after the /128.
  localparam logic [GAINW-1:0] DIR_GAIN = 18'd193536;
  // A length of 1.0 world unit in Q.8.
  localparam logic [RTW-1:0]   LEN_MIN  = 26'd256;

  localparam logic [1:0] CFG_VIEW_X   = 2'd0;
  localparam logic [1:0] CFG_VIEW_Y   = 2'd1;
  localparam logic [1:0] CFG_VIEW_Z   = 2'd2;
  localparam logic [1:0] CFG_SKY_TIME = 2'd3;

  // One classified vertex as it waits in the queue.
  typedef struct packed {
    logic [VW-1:0]  ax;
    logic           sx;
    logic [VW-1:0]  ay;
    logic           sy;
    logic [AZW-1:0] az;
    logic [VW-1:0]  scroll;
  } item_t;

  // What travels beside the length computation.
  typedef struct packed {
    logic [VW-1:0] ax;
    logic          sx;
    logic [VW-1:0] ay;
    logic          sy;
    logic [VW-1:0] scroll;
  } side_t;

endpackage

@@ design/stp_front.sv @@
// Front end: configuration registers and classification of each vertex.
module stp_front import stp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [TW-1:0]    cfg_data,
  input  logic [VW-1:0]    vert_x,
  input  logic [VW-1:0]    vert_y,
  input  logic [VW-1:0]    vert_z,
  input  logic [SPW-1:0]   scroll_speed,
  output item_t            item
);

  logic [VW-1:0] view_x_r, view_y_r, view_z_r;
  logic [TW-1:0] sky_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r   <= '0;
      view_y_r   <= '0;
      view_z_r   <= '0;
      sky_time_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_X:   view_x_r   <= cfg_data[VW-1:0];
        CFG_VIEW_Y:   view_y_r   <= cfg_data[VW-1:0];
        CFG_VIEW_Z:   view_z_r   <= cfg_data[VW-1:0];
        CFG_SKY_TIME: sky_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [VW:0]        dx, dy, dz1, nx, ny;
  logic [AZW:0]       dz3, nz;
  logic [VW+SPW-2:0]  prod;

  always_comb begin
    dx  = {vert_x[VW-1], vert_x} - {view_x_r[VW-1], view_x_r};
    dy  = {vert_y[VW-1], vert_y} - {view_y_r[VW-1], view_y_r};
    dz1 = {vert_z[VW-1], vert_z} - {view_z_r[VW-1], view_z_r};
    dz3 = {{2{dz1[VW]}}, dz1} + {dz1[VW], dz1, 1'b0};
    nx  = -dx;
    ny  = -dy;
    nz  = -dz3;
    // Only the low bits of the scroll term survive the final wrap.
    prod = sky_time_r[VW-2:0] * scroll_speed;
    item.ax     = dx[VW] ? nx[VW-1:0] : dx[VW-1:0];
    item.sx     = dx[VW];
    item.ay     = dy[VW] ? ny[VW-1:0] : dy[VW-1:0];
    item.sy     = dy[VW];
    item.az     = dz3[AZW] ? nz[AZW-1:0] : dz3[AZW-1:0];
    item.scroll = {prod[VW-2:0], 1'b0};
  end

endmodule

@@ design/stp_queue.sv @@
// Short queue between the front end and the arithmetic back end.
module stp_queue import stp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  assign full     = (cnt_r == QDEPTH[QAW:0]);
  assign empty    = (cnt_r == '0);
  assign pop_item = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

endmodule

@@ design/stp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module stp_sqrt import stp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [SQW-1:0] in_n,
  input  side_t          in_side,
  output logic           out_v,
  output logic [RTW-1:0] out_root,
  output side_t          out_side
);

  logic           v_r    [RTW];
  logic [SQW-1:0] n_r    [RTW];
  logic [RTW-1:0] root_r [RTW];
  logic [RMW-1:0] rem_r  [RTW];
  side_t          side_r [RTW];

  logic [RTW-1:0] root_nxt [RTW];
  logic [RMW-1:0] rem_nxt  [RTW];

  always_comb begin
    for (int k = 0; k < RTW; k++) begin
      logic [SQW-1:0] n;
      logic [RTW-1:0] root;
      logic [RMW-1:0] rem, remsh, trial;
      logic [SQW-1:0] sh;
      n     = (k == 0) ? in_n : n_r[(k == 0) ? 0 : k-1];
      root  = (k == 0) ? '0   : root_r[(k == 0) ? 0 : k-1];
      rem   = (k == 0) ? '0   : rem_r[(k == 0) ? 0 : k-1];
      sh    = n >> (2 * (RTW - 1 - k));
      remsh = {rem[RMW-3:0], sh[1:0]};
      trial = {root, 2'b01};
      if (remsh >= trial) begin
        rem_nxt[k]  = remsh - trial;
        root_nxt[k] = {root[RTW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = remsh;
        root_nxt[k] = {root[RTW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RTW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < RTW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= in_n;
      side_r[0] <= in_side;
      for (int k = 1; k < RTW; k++) begin
        n_r[k]    <= n_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < RTW; k++) begin
        root_r[k] <= root_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

  assign out_v    = v_r[RTW-1];
  assign out_root = root_r[RTW-1];
  assign out_side = side_r[RTW-1];

endmodule

@@ design/stp_div.sv @@
// Pipelined floor division of the scaled direction by the length, plus the scroll term.
module stp_div import stp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [VW-1:0]  in_mag,
  input  logic           in_neg,
  input  logic [RTW-1:0] in_len,
  input  logic [VW-1:0]  in_addend,
  output logic           out_v,
  output logic [VW-1:0]  out_res
);

  // Scaling stage: dividend and clamped divisor.
  logic            pv_r;
  logic [NUMW-1:0] pnum_r;
  logic [RTW-1:0]  pden_r;
  logic            pneg_r;
  logic [VW-1:0]   padd_r;

  logic            v_r   [NUMW];
  logic [NUMW-1:0] num_r [NUMW];
  logic [RTW-1:0]  den_r [NUMW];
  logic            neg_r [NUMW];
  logic [VW-1:0]   add_r [NUMW];
  logic [DRW-1:0]  rem_r [NUMW];
  logic [VW-1:0]   q_r   [NUMW];

  logic [DRW-1:0]  rem_nxt [NUMW];
  logic [VW-1:0]   q_nxt   [NUMW];

  logic            ov_r;
  logic [VW-1:0]   res_r;

  always_comb begin
    for (int j = 0; j < NUMW; j++) begin
      logic [NUMW-1:0] num;
      logic [RTW-1:0]  den;
      logic [DRW-1:0]  rem, remsh;
      logic [VW-1:0]   q;
      num   = (j == 0) ? pnum_r : num_r[(j == 0) ? 0 : j-1];
      den   = (j == 0) ? pden_r : den_r[(j == 0) ? 0 : j-1];
      rem   = (j == 0) ? '0     : rem_r[(j == 0) ? 0 : j-1];
      q     = (j == 0) ? '0     : q_r[(j == 0) ? 0 : j-1];
      remsh = {rem[DRW-2:0], num[NUMW-1-j]};
      if (remsh >= {1'b0, den}) begin
        rem_nxt[j] = remsh - {1'b0, den};
        q_nxt[j]   = {q[VW-2:0], 1'b1};
      end else begin
        rem_nxt[j] = remsh;
        q_nxt[j]   = {q[VW-2:0], 1'b0};
      end
    end
  end

  logic [VW-1:0] qa, qs;
  always_comb begin
    // A negative dividend rounds its magnitude up, then flips sign.
    qa = q_r[NUMW-1] + {{(VW-1){1'b0}}, neg_r[NUMW-1] && (rem_r[NUMW-1] != '0)};
    qs = neg_r[NUMW-1] ? -qa : qa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
      for (int j = 0; j < NUMW; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      pv_r   <= in_v;
      v_r[0] <= pv_r;
      for (int j = 1; j < NUMW; j++) v_r[j] <= v_r[j-1];
      ov_r   <= v_r[NUMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnum_r <= in_mag * DIR_GAIN;
      pden_r <= (in_len < LEN_MIN) ? LEN_MIN : in_len;
      pneg_r <= in_neg;
      padd_r <= in_addend;
      num_r[0] <= pnum_r;
      den_r[0] <= pden_r;
      neg_r[0] <= pneg_r;
      add_r[0] <= padd_r;
      for (int j = 1; j < NUMW; j++) begin
        num_r[j] <= num_r[j-1];
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        add_r[j] <= add_r[j-1];
      end
      for (int j = 0; j < NUMW; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
      res_r <= add_r[NUMW-1] + qs;
    end
  end

  assign out_v   = ov_r;
  assign out_res = res_r;

endmodule

@@ design/sky_texcoord_projection.sv @@
// Top level of the sky texture coordinate projection block.
//
// This block turns a stream of vertex positions into scrolling sky texture
// coordinates. For each vertex it forms the direction from the configured
// view origin, triples the vertical part, takes the length (never below 1.0)
// and returns s and t = (time*speed + dir*378/length)/128 in signed Q8.16,
// wrapping modulo 256. It takes one vertex per clock cycle while in_stall is
// low and returns one result per vertex in order. Each vertex passes through
// the squaring and summing stages, the 26 stages of the square root, and the
// scaling stage, 42 quotient stages and result stage of each divider. A
// four-entry queue sits between the classifying front end and the pipelined
// back end, so the input keeps taking transfers for a while when the output
// stalls. Configuration registers are written through the cfg_ port and
// should only change while no vertex is in flight.
module sky_texcoord_projection import stp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [TW-1:0]   cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [VW-1:0]   in_vert_x,
  input  logic [VW-1:0]   in_vert_y,
  input  logic [VW-1:0]   in_vert_z,
  input  logic [SPW-1:0]  in_scroll_speed,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [VW-1:0]   out_tex_s,
  output logic [VW-1:0]   out_tex_t
);

  item_t front_item, q_item;
  logic  q_full, q_empty, push, pop, en;

  // The whole back end moves as one; it holds only while a finished result
  // waits for the consumer.
  assign en       = !(out_valid && out_stall);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign pop      = en && !q_empty;

  stp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vert_x       (in_vert_x),
    .vert_y       (in_vert_y),
    .vert_z       (in_vert_z),
    .scroll_speed (in_scroll_speed),
    .item         (front_item)
  );

  stp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Squares stage, then the sum of squares stage.
  logic              sa_v_r, sb_v_r;
  logic [2*VW-1:0]   sqx_r, sqy_r;
  logic [2*AZW-1:0]  sqz_r;
  side_t             sa_side_r, sb_side_r;
  logic [SQW-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= pop;
      sb_v_r <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= q_item.ax * q_item.ax;
      sqy_r     <= q_item.ay * q_item.ay;
      sqz_r     <= q_item.az * q_item.az;
      sa_side_r <= '{ax: q_item.ax, sx: q_item.sx, ay: q_item.ay, sy: q_item.sy,
                     scroll: q_item.scroll};
      sum_r     <= {{(SQW-2*VW){1'b0}}, sqx_r} + {{(SQW-2*VW){1'b0}}, sqy_r} + sqz_r;
      sb_side_r <= sa_side_r;
    end
  end

  logic           rt_v;
  logic [RTW-1:0] rt_len;
  side_t          rt_side;

  stp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sb_v_r),
    .in_n     (sum_r),
    .in_side  (sb_side_r),
    .out_v    (rt_v),
    .out_root (rt_len),
    .out_side (rt_side)
  );

  logic t_v_unused;

  stp_div u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (rt_v),
    .in_mag    (rt_side.ax),
    .in_neg    (rt_side.sx),
    .in_len    (rt_len),
    .in_addend (rt_side.scroll),
    .out_v     (out_valid),
    .out_res   (out_tex_s)
  );

  // Both dividers run in lockstep; the s divider's valid speaks for both.
  stp_div u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (rt_v),
    .in_mag    (rt_side.ay),
    .in_neg    (rt_side.sy),
    .in_len    (rt_len),
    .in_addend (rt_side.scroll),
    .out_v     (t_v_unused),
    .out_res   (out_tex_t)
  );

endmodule

@@ design/stp_checker.sv @@
// Port-level checker for the sky texture coordinate projection block, with its bind.
module stp_checker import stp_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input logic [VW-1:0]  out_tex_s,
  input logic [VW-1:0]  out_tex_t
);

  // Transfers accepted but not yet delivered.
  logic [7:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + {7'd0, in_valid && !in_stall}
                               - {7'd0, out_valid && !out_stall};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tex_s) && $stable(out_tex_t))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 8'd0)
    else $error("result without an accepted vertex");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> inflight_r >= 8'(QDEPTH))
    else $error("input stalled with the queue not full");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channel busy right after reset");

endmodule

bind sky_texcoord_projection stp_checker u_stp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_tex_s (out_tex_s),
  .out_tex_t (out_tex_t)
);

@@ dv/stp_checker.sv @@
// Predictor and scoreboard that watches the sky texture coordinate projection channels.
module stp_scoreboard import stp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [TW-1:0]  cfg_data,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic [VW-1:0]  in_vert_x,
  input  logic [VW-1:0]  in_vert_y,
  input  logic [VW-1:0]  in_vert_z,
  input  logic [SPW-1:0] in_scroll_speed,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [VW-1:0]  out_tex_s,
  input  logic [VW-1:0]  out_tex_t,
  output int             errors,
  output int             pending,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VW-1:0] tex_s;
    logic [VW-1:0] tex_t;
  } texcoord_t;

  logic signed [VW-1:0] eye_x, eye_y, eye_z;
  logic [TW-1:0]        clock_time;
  texcoord_t            texcoord_q[$];

  assign pending = texcoord_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Division that rounds toward minus infinity.
  function automatic longint floor_quot(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic texcoord_t project_vertex(input logic signed [VW-1:0] vx,
                                               input logic signed [VW-1:0] vy,
                                               input logic signed [VW-1:0] vz,
                                               input logic [SPW-1:0] speed);
    longint dx, dy, dz, len, scroll;
    texcoord_t r;
    dx = longint'(vx) - longint'(eye_x);
    dy = longint'(vy) - longint'(eye_y);
    dz = 3 * (longint'(vz) - longint'(eye_z));
    len = longint'(int_sqrt(dx * dx + dy * dy + dz * dz));
    if (len < 256) len = 256;
    scroll = 2 * longint'(clock_time) * longint'(speed);
    r.tex_s = VW'(scroll + floor_quot(dx * longint'(DIR_GAIN), len));
    r.tex_t = VW'(scroll + floor_quot(dy * longint'(DIR_GAIN), len));
    return r;
  endfunction

  always @(posedge clk) begin
    texcoord_t want;
    if (!rst_n) begin
      eye_x <= '0;
      eye_y <= '0;
      eye_z <= '0;
      clock_time <= '0;
      texcoord_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIEW_X:   eye_x <= cfg_data[VW-1:0];
          CFG_VIEW_Y:   eye_y <= cfg_data[VW-1:0];
          CFG_VIEW_Z:   eye_z <= cfg_data[VW-1:0];
          CFG_SKY_TIME: clock_time <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        texcoord_q.push_back(project_vertex(in_vert_x, in_vert_y, in_vert_z, in_scroll_speed));
      if (out_valid && !out_stall) begin
        if (texcoord_q.size() == 0) begin
          $error("result transfer with no expected result: s=%h t=%h", out_tex_s, out_tex_t);
          errors++;
        end else begin
          want = texcoord_q.pop_front();
          checked++;
          if (out_tex_s !== want.tex_s) begin
            $error("tex_s mismatch: expected %h actual %h", want.tex_s, out_tex_s);
            errors++;
          end
          if (out_tex_t !== want.tex_t) begin
            $error("tex_t mismatch: expected %h actual %h", want.tex_t, out_tex_t);
            errors++;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_sky_texcoord_projection.sv @@
// Testbench top for the sky texture coordinate projection block: stimulus and verdict.
module tb_sky_texcoord_projection;
  import stp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;
  localparam int RANDOM_PER_PHASE = 225;
  localparam int DRAIN_CYCLES = 100;  // extra idle time after the last result comes back

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_VIEW_X;
  logic [TW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VW-1:0] in_vert_x = '0, in_vert_y = '0, in_vert_z = '0;
  logic [SPW-1:0] in_scroll_speed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VW-1:0] out_tex_s, out_tex_t;

  int errors, pending, checked;
  int drain_errors = 0;
  int cycles = 0;
  int vertices_sent = 0;
  // Percent of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // A request for one long receiver hold-off, serviced by the stall process.
  bit hold_off_req = 1'b0;
  int hold_off_len = 0;

  always #5 clk = ~clk;

  sky_texcoord_projection DUT (.*);

  stp_scoreboard u_checker (.*);

  // The run is bounded so a hung handshake cannot spin forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver side. A long hold-off is counted here in cycles of its own, while
  // the sender keeps offering vertices so that the internal queue fills and
  // the block pushes back on its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (hold_off_len) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Writes one register. The block must be idle when this is called.
  task automatic write_reg(input logic [1:0] idx, input logic [TW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one vertex and holds it steady until the block takes the transfer.
  // Valid is left high afterwards; the next call or wait_idle lowers it when the stream pauses.
  task automatic send_vertex(input logic [VW-1:0] vx, input logic [VW-1:0] vy,
                             input logic [VW-1:0] vz, input logic [SPW-1:0] speed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_vert_x = VW'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_vert_x = vx;
    in_vert_y = vy;
    in_vert_z = vz;
    in_scroll_speed = speed;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected result has come back, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A random vertex: mostly spread over the full range, some close to the
  // viewer so that the length floor and small directions get exercised.
  task automatic send_random_vertex();
    logic [SPW-1:0] speed;
    logic [VW-1:0] vx, vy, vz;
    case ($urandom_range(3))
      0: speed = 8'd8;
      1: speed = 8'd16;
      default: speed = SPW'($urandom);
    endcase
    if ($urandom_range(3) == 0) begin
      vx = u_checker.eye_x + VW'($urandom_range(512) - 256);
      vy = u_checker.eye_y + VW'($urandom_range(512) - 256);
      vz = u_checker.eye_z + VW'($urandom_range(200) - 100);
    end else begin
      vx = VW'($urandom);
      vy = VW'($urandom);
      vz = VW'($urandom);
    end
    send_vertex(vx, vy, vz, speed);
  endtask

  localparam logic [VW-1:0] VMAX = 24'h7FFFFF;
  localparam logic [VW-1:0] VMIN = 24'h800000;

  initial begin
    int mode;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 45 : (mode == 3) ? 34 : 0;
      recv_stall_pct = (mode == 2) ? 45 : (mode == 3) ? 34 : 0;

      // Settings change only while nothing is in flight. Upper data bits carry
      // filler patterns or random values so that the view registers must ignore them.
      case (p)
        0: ;  // registers stay at their reset values
        1: begin
          write_reg(CFG_VIEW_X, {8'hA5, VMIN});
          write_reg(CFG_VIEW_Y, {8'h5A, VMIN});
          write_reg(CFG_VIEW_Z, {8'hFF, VMIN});
          write_reg(CFG_SKY_TIME, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CFG_VIEW_X, {8'h00, VMAX});
          write_reg(CFG_VIEW_Y, {8'hFF, VMAX});
          write_reg(CFG_VIEW_Z, {8'h3C, VMAX});
          write_reg(CFG_SKY_TIME, 32'h0);
        end
        default: begin
          write_reg(CFG_VIEW_X, $urandom);
          write_reg(CFG_VIEW_Y, $urandom);
          write_reg(CFG_VIEW_Z, (p % 2) ? $urandom : $urandom_range(4096));
          write_reg(CFG_SKY_TIME, $urandom);
        end
      endcase

      if (p <= 2) begin
        // Directed corners: vertex at the viewer, each axis at its extremes,
        // both speed extremes and the usual back and front layer speeds.
        send_vertex(u_checker.eye_x, u_checker.eye_y, u_checker.eye_z, 8'd0);
        send_vertex(u_checker.eye_x, u_checker.eye_y, u_checker.eye_z, 8'd255);
        send_vertex(u_checker.eye_x + 24'd1, u_checker.eye_y - 24'd1, u_checker.eye_z, 8'd8);
        send_vertex(VMAX, VMAX, VMAX, 8'd255);
        send_vertex(VMIN, VMIN, VMIN, 8'd255);
        send_vertex(VMAX, VMIN, 24'd0, 8'd16);
        send_vertex(VMIN, VMAX, VMAX, 8'd8);
        send_vertex(24'd0, 24'd0, VMIN, 8'd1);
        send_vertex(24'hFFFFFF, 24'h000100, 24'hFFFF00, 8'h80);
        send_vertex(24'h555555, 24'hAAAAAA, 24'h555555, 8'h55);
        send_vertex(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 8'hAA);
      end

      if (p == 5) begin
        hold_off_len = 400;
        hold_off_req = 1'b1;
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // Occasional runs with no gaps at all, even in idling phases.
        if (i % 60 < 10) send_idle_pct = 0;
        else send_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 34 : 0;
        send_random_vertex();
      end
      wait_idle();
    end

    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
      drain_errors++;
    end
    $display("Sent %0d vertices over %0d phases of settings and idling; %0d results checked.",
             vertices_sent, NUM_PHASES, checked);
    $display("Covered the length floor, extreme origins and times, and a long output hold-off.");
    if (errors == 0 && drain_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
